/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the sensor poll and recovery controller.
// Assertions are compiled out when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define SPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SPR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/spr_pkg.sv */
// Package for the sensor poll and recovery controller: payload and config types,
// state and link codes, register indexes. No dependencies.
package spr_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CNT_BITS   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_READY_LINE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READY_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READ_PRESCALER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_PERIOD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEINIT_PERIOD   = 3'd6;

  // Controller states.
  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_INACTIVE = 3'd1,
    ST_WAIT     = 3'd2,
    ST_READ     = 3'd3,
    ST_DEINIT   = 3'd4,
    ST_RECOVER  = 3'd5
  } spr_state_t;

  // Link status codes.
  typedef enum logic [1:0] {
    LINK_READY    = 2'd0,
    LINK_WAITING  = 2'd1,
    LINK_COMPLETE = 2'd2
  } spr_link_t;

  // Input operation codes.
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RX_DONE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [11:0] ready_line_level;
  } spr_in_t;

  typedef struct packed {
    logic [2:0] fsm_state_out;
    logic       start_read;
    logic       bus_disable;
    logic       bus_init;
    logic       data_decoded;
    logic [1:0] link_status;
    logic       streaming;
  } spr_out_t;

  typedef struct packed {
    logic        enable;
    logic        use_ready_line;
    logic [11:0] ready_threshold;
    logic [15:0] poll_period;
    logic [13:0] read_prescaler;
    logic [15:0] reset_period;
    logic [14:0] deinit_period;
  } spr_cfg_t;

endpackage

/* rtl/spr_core.sv */
// Controller state and the per-item step: ready flag, state machine, timer and counters.
// Depends on spr_pkg.
module spr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  spr_pkg::spr_in_t  item,
  input  spr_pkg::spr_cfg_t cfg,
  output spr_pkg::spr_out_t res
);
  import spr_pkg::*;

  spr_state_t            state_r, state_nxt;
  spr_link_t             link_r, link_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt, timer_w;
  logic [CNT_BITS-1:0]   rst_cnt_r, rst_cnt_nxt;
  logic [CNT_BITS-1:0]   presc_r, presc_nxt, presc_inc;
  logic                  ready_r, ready_nxt;
  logic                  rd_pulse, dis_pulse, ini_pulse, dec_pulse;
  logic [16:0]           presc_x5;
  logic [15:0]           deinit_x2;

  // Fixed scaled limits from the configuration.
  assign presc_x5  = {3'b000, cfg.read_prescaler} + {1'b0, cfg.read_prescaler, 2'b00};
  assign deinit_x2 = {cfg.deinit_period, 1'b0};
  assign presc_inc = presc_r + 1'b1;

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_DISABLED;
      link_r    <= LINK_READY;
      timer_r   <= '0;
      rst_cnt_r <= '0;
      presc_r   <= '0;
      ready_r   <= 1'b0;
    end else if (step_en) begin
      state_r   <= state_nxt;
      link_r    <= link_nxt;
      timer_r   <= timer_nxt;
      rst_cnt_r <= rst_cnt_nxt;
      presc_r   <= presc_nxt;
      ready_r   <= ready_nxt;
    end
  end

  // Next state, counters and pulses for one item.
  always_comb begin
    state_nxt   = state_r;
    link_nxt    = link_r;
    timer_w     = timer_r;
    rst_cnt_nxt = rst_cnt_r;
    presc_nxt   = presc_r;
    ready_nxt   = ready_r;
    rd_pulse    = 1'b0;
    dis_pulse   = 1'b0;
    ini_pulse   = 1'b0;
    dec_pulse   = 1'b0;
    timer_nxt   = timer_r;

    if (item.operation == OP_TICK) begin
      ready_nxt = cfg.use_ready_line ? (item.ready_line_level > cfg.ready_threshold) : 1'b1;
      unique case (state_r)
        ST_DISABLED: begin
          if (cfg.enable) begin
            state_nxt = ST_INACTIVE;
            timer_w   = '0;
          end
        end
        ST_INACTIVE: begin
          if (!cfg.enable) begin
            state_nxt = ST_DISABLED;
          end else if (ready_nxt) begin
            state_nxt = ST_WAIT;
            timer_w   = '0;
          end
        end
        ST_WAIT: begin
          if (rst_cnt_r > cfg.reset_period) begin
            state_nxt   = ST_DEINIT;
            timer_w     = '0;
            rst_cnt_nxt = '0;
          end else if (!cfg.enable) begin
            state_nxt = ST_DISABLED;
          end else begin
            if (!ready_nxt) begin
              state_nxt = ST_INACTIVE;
            end
            if (timer_r > cfg.poll_period) begin
              timer_w = '0;
            end
            rd_pulse    = (timer_w == '0);
            rst_cnt_nxt = rst_cnt_r + 1'b1;
          end
        end
        ST_READ: begin
          if (!cfg.enable) begin
            timer_w   = '0;
            state_nxt = ST_DISABLED;
          end else if (ready_nxt) begin
            if (presc_r == '0) begin
              rd_pulse = 1'b1;
              link_nxt = LINK_WAITING;
            end
            if ({1'b0, timer_r} > presc_x5) begin
              state_nxt = ST_DEINIT;
              timer_w   = '0;
              link_nxt  = LINK_READY;
            end
            presc_nxt = (presc_inc >= {2'b00, cfg.read_prescaler}) ? '0 : presc_inc;
          end else begin
            timer_w   = '0;
            state_nxt = ST_INACTIVE;
            link_nxt  = LINK_READY;
          end
        end
        ST_DEINIT: begin
          if (timer_r >= {1'b0, cfg.deinit_period}) begin
            timer_w   = '0;
            dis_pulse = 1'b1;
            state_nxt = ST_RECOVER;
          end
        end
        ST_RECOVER: begin
          if (timer_r == {1'b0, cfg.deinit_period}) begin
            ini_pulse = 1'b1;
          end else if (timer_r >= deinit_x2) begin
            timer_w   = '0;
            state_nxt = ST_WAIT;
          end
        end
        default: begin
          // Unused codes only advance the timer.
        end
      endcase
      timer_nxt = timer_w + 1'b1;
    end else begin
      // Receive complete: wait moves to read, read marks the frame decoded.
      if (state_r == ST_WAIT) begin
        state_nxt = ST_READ;
      end else if (state_r == ST_READ) begin
        dec_pulse = 1'b1;
        link_nxt  = LINK_COMPLETE;
        timer_nxt = '0;
      end
    end
  end

  // Result fields are taken after the step.
  always_comb begin
    res.fsm_state_out = state_nxt;
    res.start_read    = rd_pulse;
    res.bus_disable   = dis_pulse;
    res.bus_init      = ini_pulse;
    res.data_decoded  = dec_pulse;
    res.link_status   = link_nxt;
    res.streaming     = ready_nxt && cfg.enable && (state_nxt == ST_READ);
  end

endmodule

/* rtl/sensor_poll_recovery_fsm.sv */
// Top level of the sensor poll and recovery controller: config registers,
// input register, result register and handshakes. Depends on spr_pkg, spr_core
// and assert_macros.svh.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    spr_in_t  (operation, ready line level)
//   out_      output     out_valid / out_ready  spr_out_t (state, pulses, link, streaming)
//   cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// One item per clock cycle while out_ready keeps the result moving; a result passes
// through the input register, then the result register after the single-pass step logic.
// Reset (rst_n low, synchronous) empties both registers and restores defaults.
// A stalled result holds the result register; the input register still takes one
// more item, and in_ready drops only while both registers are full.
`include "assert_macros.svh"

module sensor_poll_recovery_fsm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  spr_pkg::spr_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output spr_pkg::spr_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import spr_pkg::*;

  spr_cfg_t  cfg_r;
  logic      in_valid_r;
  spr_in_t   in_item_r;
  logic      out_valid_r;
  spr_out_t  out_data_r;
  spr_out_t  step_res;
  logic      advance;
  logic      step_en;
  logic      in_xfer;

  assign advance  = !out_valid_r || out_ready;
  assign step_en  = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b1;
      cfg_r.use_ready_line  <= 1'b1;
      cfg_r.ready_threshold <= 12'd2048;
      cfg_r.poll_period     <= 16'd200;
      cfg_r.read_prescaler  <= 14'd10;
      cfg_r.reset_period    <= 16'd10000;
      cfg_r.deinit_period   <= 15'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:          cfg_r.enable          <= cfg_wdata[0];
        REG_USE_READY_LINE:  cfg_r.use_ready_line  <= cfg_wdata[0];
        REG_READY_THRESHOLD: cfg_r.ready_threshold <= cfg_wdata[11:0];
        REG_POLL_PERIOD:     cfg_r.poll_period     <= cfg_wdata;
        REG_READ_PRESCALER:  cfg_r.read_prescaler  <= cfg_wdata[13:0];
        REG_RESET_PERIOD:    cfg_r.reset_period    <= cfg_wdata;
        REG_DEINIT_PERIOD:   cfg_r.deinit_period   <= cfg_wdata[14:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Input register: holds one item until the step logic takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_data;
    end
  end

  // Step logic and controller state.
  spr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the pipeline and the result fields.
  `SPR_ASSERT_NOW(a_ready_low_only_full, clk, rst_n, !in_ready, in_valid_r && out_valid_r)
  `SPR_ASSERT_NOW(a_stream_in_read, clk, rst_n, out_valid_r && out_data_r.streaming, out_data_r.fsm_state_out == ST_READ)
  `SPR_ASSERT_NOW(a_bus_pulses_exclusive, clk, rst_n, out_valid_r, $onehot0({out_data_r.bus_disable, out_data_r.bus_init, out_data_r.data_decoded}))
  `SPR_ASSERT_NOW(a_disable_enters_recover, clk, rst_n, out_valid_r && out_data_r.bus_disable, out_data_r.fsm_state_out == ST_RECOVER)
  `SPR_ASSERT_NEXT(a_step_fills_result, clk, rst_n, step_en, out_valid_r)

endmodule

/* tb/sensor_poll_recovery_fsm_checker.sv */
// Checker for the sensor poll and recovery controller: mirrors the controller state,
// predicts one status record per input transfer and compares each output transfer.
// Depends on spr_pkg only; watches the block's ports and never drives them.
module sensor_poll_recovery_fsm_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  spr_pkg::spr_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  spr_pkg::spr_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spr_pkg::*;

  // Mirrored register file and controller state.
  spr_cfg_t                 settings;
  spr_state_t               ctl_state;
  logic [TIMER_BITS-1:0]    tick_count;
  logic [CNT_BITS-1:0]      reset_count;
  logic [CNT_BITS-1:0]      prescale_count;
  spr_link_t                link_code;
  logic                     ready_seen;

  // Status records predicted but not yet seen on the output channel.
  spr_out_t status_queue[$];

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Applies one tick or receive-complete event to the mirrored state and
  // returns the status record that the block should report for it.
  function automatic spr_out_t advance_controller(spr_in_t item);
    spr_out_t    res;
    logic        on;
    logic        rdy;
    int unsigned read_timeout;
    int unsigned recover_end;
    res = '0;
    if (item.operation == OP_TICK) begin
      on = settings.enable;
      if (settings.use_ready_line) begin
        ready_seen = (item.ready_line_level > settings.ready_threshold);
      end else begin
        ready_seen = 1'b1;
      end
      rdy = ready_seen;
      read_timeout = 32'(settings.read_prescaler) * 5;
      recover_end = 32'(settings.deinit_period) * 2;
      case (ctl_state)
        ST_DISABLED: begin
          if (on) begin
            ctl_state = ST_INACTIVE;
            tick_count = '0;
          end
        end
        ST_INACTIVE: begin
          if (!on) begin
            ctl_state = ST_DISABLED;
          end else if (rdy) begin
            ctl_state = ST_WAIT;
            tick_count = '0;
          end
        end
        ST_WAIT: begin
          // The periodic bus reset wins over everything else in this state.
          if (reset_count > settings.reset_period) begin
            ctl_state = ST_DEINIT;
            tick_count = '0;
            reset_count = '0;
          end else if (!on) begin
            ctl_state = ST_DISABLED;
          end else begin
            if (!rdy) ctl_state = ST_INACTIVE;
            if (tick_count > settings.poll_period) tick_count = '0;
            if (tick_count == '0) res.start_read = 1'b1;
            reset_count = reset_count + 1'b1;
          end
        end
        ST_READ: begin
          if (!on) begin
            tick_count = '0;
            ctl_state = ST_DISABLED;
          end else if (rdy) begin
            if (prescale_count == '0) begin
              res.start_read = 1'b1;
              link_code = LINK_WAITING;
            end
            if (32'(tick_count) > read_timeout) begin
              ctl_state = ST_DEINIT;
              tick_count = '0;
              link_code = LINK_READY;
            end
            prescale_count = prescale_count + 1'b1;
            if (prescale_count >= settings.read_prescaler) prescale_count = '0;
          end else begin
            // Ready line dropped while streaming: back to inactive, link idle.
            tick_count = '0;
            ctl_state = ST_INACTIVE;
            link_code = LINK_READY;
          end
        end
        ST_DEINIT: begin
          if (tick_count >= settings.deinit_period) begin
            tick_count = '0;
            res.bus_disable = 1'b1;
            ctl_state = ST_RECOVER;
          end
        end
        ST_RECOVER: begin
          if (tick_count == settings.deinit_period) begin
            res.bus_init = 1'b1;
          end else if (32'(tick_count) >= recover_end) begin
            tick_count = '0;
            ctl_state = ST_WAIT;
          end
        end
        default: ;
      endcase
      tick_count = tick_count + 1'b1;
    end else begin
      // Receive complete only matters while waiting or reading.
      if (ctl_state == ST_WAIT) begin
        ctl_state = ST_READ;
      end else if (ctl_state == ST_READ) begin
        res.data_decoded = 1'b1;
        link_code = LINK_COMPLETE;
        tick_count = '0;
      end
    end
    res.fsm_state_out = ctl_state;
    res.link_status = link_code;
    res.streaming = ready_seen && (ctl_state == ST_READ) && settings.enable;
    return res;
  endfunction

  // Track register writes, predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    spr_out_t want;
    if (!rst_n) begin
      settings = '{enable: 1'b1, use_ready_line: 1'b1, ready_threshold: 12'd2048,
                   poll_period: 16'd200, read_prescaler: 14'd10,
                   reset_period: 16'd10000, deinit_period: 15'd10};
      ctl_state = ST_DISABLED;
      tick_count = '0;
      reset_count = '0;
      prescale_count = '0;
      link_code = LINK_READY;
      ready_seen = 1'b0;
      status_queue.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:          settings.enable = cfg_wdata[0];
          REG_USE_READY_LINE:  settings.use_ready_line = cfg_wdata[0];
          REG_READY_THRESHOLD: settings.ready_threshold = cfg_wdata[11:0];
          REG_POLL_PERIOD:     settings.poll_period = cfg_wdata[15:0];
          REG_READ_PRESCALER:  settings.read_prescaler = cfg_wdata[13:0];
          REG_RESET_PERIOD:    settings.reset_period = cfg_wdata[15:0];
          REG_DEINIT_PERIOD:   settings.deinit_period = cfg_wdata[14:0];
          default: ;
        endcase
      end
      // The output side goes first: a result is never from the same cycle's input.
      if (out_valid && out_ready) begin
        if (status_queue.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), 0);
        end else begin
          want = status_queue.pop_front();
          if (out_data.fsm_state_out !== want.fsm_state_out)
            report_mismatch("fsm_state_out", 32'(out_data.fsm_state_out),
                            32'(want.fsm_state_out));
          if (out_data.start_read !== want.start_read)
            report_mismatch("start_read", 32'(out_data.start_read), 32'(want.start_read));
          if (out_data.bus_disable !== want.bus_disable)
            report_mismatch("bus_disable", 32'(out_data.bus_disable),
                            32'(want.bus_disable));
          if (out_data.bus_init !== want.bus_init)
            report_mismatch("bus_init", 32'(out_data.bus_init), 32'(want.bus_init));
          if (out_data.data_decoded !== want.data_decoded)
            report_mismatch("data_decoded", 32'(out_data.data_decoded),
                            32'(want.data_decoded));
          if (out_data.link_status !== want.link_status)
            report_mismatch("link_status", 32'(out_data.link_status),
                            32'(want.link_status));
          if (out_data.streaming !== want.streaming)
            report_mismatch("streaming", 32'(out_data.streaming), 32'(want.streaming));
        end
      end
      if (in_valid && in_ready) begin
        status_queue.push_back(advance_controller(in_data));
      end
    end
    pending <= status_queue.size();
  end

endmodule

/* tb/sensor_poll_recovery_fsm_test.sv */
// Testbench top for the sensor poll and recovery controller: clock, reset, register
// writes, tick and receive stimulus with random idling, and the final verdict.
// Depends on spr_pkg, the block's RTL and sensor_poll_recovery_fsm_checker.
module sensor_poll_recovery_fsm_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  spr_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  spr_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    errors;
  int                    pending;
  int                    cycles;

  // Stimulus knobs: current register values, receive density, no-idle stretches.
  spr_cfg_t cur_cfg;
  int       rx_pct;
  bit       calm_in;
  bit       calm_out;

  sensor_poll_recovery_fsm u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sensor_poll_recovery_fsm_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sensor_poll_recovery_fsm_test: FAIL");
    $finish;
  end

  // Result side: a random stall before each transfer, with stall-free stretches.
  initial begin
    int gap;
    out_ready = 1'b0;
    calm_out = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      gap = calm_out ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic spr_in_t make_item(logic op, logic [11:0] level);
    spr_in_t item;
    item.operation = op;
    item.ready_line_level = level;
    return item;
  endfunction

  // Offers one item after a random gap and returns at the edge of its transfer.
  task automatic send_item(spr_in_t item);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender off until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Writes the whole register file; only called while the block is idle.
  task automatic apply_settings(spr_cfg_t s);
    write_reg(REG_ENABLE, 32'(s.enable));
    write_reg(REG_USE_READY_LINE, 32'(s.use_ready_line));
    write_reg(REG_READY_THRESHOLD, 32'(s.ready_threshold));
    write_reg(REG_POLL_PERIOD, 32'(s.poll_period));
    write_reg(REG_READ_PRESCALER, 32'(s.read_prescaler));
    write_reg(REG_RESET_PERIOD, 32'(s.reset_period));
    write_reg(REG_DEINIT_PERIOD, 32'(s.deinit_period));
    cfg_we <= 1'b0;
    cur_cfg = s;
  endtask

  // Register values per phase: the first few are the range extremes, the rest
  // are small random values so that every state is visited often.
  function automatic spr_cfg_t draw_settings(int phase);
    spr_cfg_t s;
    s.enable = ($urandom_range(0, 9) != 0);
    s.use_ready_line = ($urandom_range(0, 3) != 0);
    s.ready_threshold = 12'($urandom_range(0, 4095));
    s.poll_period = 16'($urandom_range(0, 12));
    s.read_prescaler = 14'($urandom_range(1, 6));
    s.reset_period = 16'($urandom_range(0, 40));
    s.deinit_period = 15'($urandom_range(1, 4));
    case (phase)
      0, 1: begin
        s.enable = 1'b1;
        s.use_ready_line = (phase == 0);
        s.ready_threshold = 12'd4095;
        s.poll_period = 16'd65535;
        s.read_prescaler = 14'd13107;
        s.reset_period = 16'd65535;
        s.deinit_period = 15'd32767;
      end
      2: begin
        s.enable = 1'b1;
        s.use_ready_line = 1'b0;
        s.ready_threshold = 12'd0;
        s.poll_period = 16'd0;
        s.read_prescaler = 14'd0;
        s.reset_period = 16'd0;
        s.deinit_period = 15'd1;
      end
      3: begin
        s.enable = 1'b0;
        s.ready_threshold = 12'd0;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Mostly well-formed ticks and receive events around the threshold, a little noise.
  function automatic spr_in_t random_item();
    spr_in_t     item;
    int unsigned thr;
    int          r;
    r = $urandom_range(0, 99);
    thr = 32'(cur_cfg.ready_threshold);
    if (r < 3) begin
      item.operation = 1'($urandom_range(0, 1));
      item.ready_line_level = 12'($urandom_range(0, 4095));
    end else begin
      item.operation = ($urandom_range(0, 99) < rx_pct) ? OP_RX_DONE : OP_TICK;
      if (!cur_cfg.use_ready_line || thr == 4095) begin
        item.ready_line_level = 12'($urandom_range(0, 4095));
      end else if ($urandom_range(0, 99) < 7) begin
        item.ready_line_level = 12'($urandom_range(thr, 0));
      end else begin
        item.ready_line_level = 12'($urandom_range(4095, thr + 1));
      end
    end
    return item;
  endfunction

  initial begin
    spr_cfg_t s;
    int       count;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm_in = 1'b0;
    rx_pct = 20;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk: short poll, zero prescaler, quick periodic reset, short recovery.
    s = '{enable: 1'b1, use_ready_line: 1'b1, ready_threshold: 12'd2048,
          poll_period: 16'd1, read_prescaler: 14'd0,
          reset_period: 16'd4, deinit_period: 15'd1};
    apply_settings(s);
    send_item(make_item(OP_RX_DONE, 12'd0));       // ignored while disabled
    send_item(make_item(OP_TICK, 12'd2048));       // disabled to inactive
    send_item(make_item(OP_TICK, 12'd2048));       // level equal to threshold: not ready
    send_item(make_item(OP_TICK, 12'd4095));       // inactive to wait
    send_item(make_item(OP_TICK, 12'd4095));
    send_item(make_item(OP_TICK, 12'd4095));       // poll timer restarts, read request
    send_item(make_item(OP_RX_DONE, 12'd4095));    // wait to read
    send_item(make_item(OP_TICK, 12'd4095));       // read request; zero prescaler times the read out into deinit
    send_item(make_item(OP_TICK, 12'd4095));
    send_item(make_item(OP_RX_DONE, 12'd0));       // ignored outside wait and read
    send_item(make_item(OP_TICK, 12'd0));          // recover: bus init
    send_item(make_item(OP_TICK, 12'd4095));
    repeat (6) send_item(make_item(OP_TICK, 12'd4095));  // periodic reset into deinit
    send_item(make_item(OP_RX_DONE, 12'd4095));    // ignored outside wait and read
    repeat (5) send_item(make_item(OP_TICK, 12'd3000));  // recover back to wait, then polling
    drain_results();

    // Random phases, each with fresh register values written while idle.
    for (int phase = 0; phase < 16; phase++) begin
      apply_settings(draw_settings(phase));
      rx_pct = $urandom_range(5, 35);
      count = (phase < 4) ? 50 : 160;
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(0, 49) == 0) calm_in = !calm_in;
        send_item(random_item());
        if ($urandom_range(0, 199) == 0) drain_results();
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("sensor_poll_recovery_fsm_test: PASS");
    end else begin
      $display("sensor_poll_recovery_fsm_test: FAIL");
    end
    $finish;
  end

endmodule
